[hw/rtl/hsa_pkg.sv]
// ----------------------------------------------------------------------------
// Handle slot ID allocator package
// Shared beat types, mode codes and status codes of the allocator.
// ----------------------------------------------------------------------------
package hsa_pkg;

  localparam int unsigned HandleW = 32;
  localparam int unsigned IdW     = 6;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ModeW   = 2;

  // Request modes.
  localparam logic [ModeW-1:0] ModeAlloc    = 2'd0;
  localparam logic [ModeW-1:0] ModeFreeId   = 2'd1;
  localparam logic [ModeW-1:0] ModeFreeHdl  = 2'd2;
  localparam logic [ModeW-1:0] ModeClearAll = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] StNew     = 3'd0;
  localparam logic [StatusW-1:0] StHeld    = 3'd1;
  localparam logic [StatusW-1:0] StFreed   = 3'd2;
  localparam logic [StatusW-1:0] StIgnored = 3'd3;
  localparam logic [StatusW-1:0] StFull    = 3'd4;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [HandleW-1:0] handle;
    logic [IdW-1:0]     slot_id;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]     result_id;
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     used_count;
  } rsp_t;

endpackage

[hw/rtl/handle_slot_id_allocator_top.sv]
// ----------------------------------------------------------------------------
// Handle slot ID allocator
// Maps nonzero object handles to slot IDs 1..SLOTS held in a single-port RAM.
// ----------------------------------------------------------------------------
// Allocate and free by handle read every slot of the RAM in turn and end with a
// final step that writes the slot back when it changes; free by ID reads one slot
// and writes it back cleared when it is held; clear all writes every slot; an ignored request is answered from idle.
// Throughput: one request at a time; start is taken again in the cycle the
// result beat is shown. The receiver cannot stall: each result beat lasts one
// cycle. After reset, busy stays high while the RAM is swept to zero; no result
// beat comes from that sweep.
// ----------------------------------------------------------------------------
module handle_slot_id_allocator_top #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hsa_pkg::req_t req_i,
  output logic          res_valid_o,
  output hsa_pkg::rsp_t res_o
);

  // Only the low HANDLE_BITS bits of a handle take part, so the RAM is no
  // wider than the handle field and no wider than HANDLE_BITS.
  localparam int unsigned IdxW   = $clog2(SLOTS);
  localparam int unsigned StoreW = (HANDLE_BITS < hsa_pkg::HandleW) ? HANDLE_BITS
                                                                    : hsa_pkg::HandleW;

  logic              mem_en;
  logic              mem_we;
  logic [IdxW-1:0]   mem_addr;
  logic [StoreW-1:0] mem_wdata;
  logic [StoreW-1:0] mem_rdata;

  logic              rsp_valid;
  hsa_pkg::rsp_t     rsp;

  logic              res_valid_q;
  hsa_pkg::rsp_t     res_q;

  // The controller walks the slot RAM: a full scan for allocate and free by
  // handle, one read-modify-write for free by ID, and a write sweep for clear
  // all and after reset. An empty slot is stored as handle zero.
  hsa_ctrl #(
    .SLOTS      (SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp),
    .mem_en_o   (mem_en),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  hsa_ram #(
    .Width(StoreW),
    .Depth(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // The result beat is registered, so it is shown for exactly one cycle while
  // the controller is already back to idle and free to take the next start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid) begin
      res_q <= rsp;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/hsa_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
module hsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/hsa_ctrl.sv]
// ----------------------------------------------------------------------------
// Handle slot ID allocator controller
// Sequences table scans, single-slot updates and clearing sweeps over the
// slot memory and keeps the occupied count.
// ----------------------------------------------------------------------------
module hsa_ctrl #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned HANDLE_BITS = 32,
  localparam int unsigned IdxW   = $clog2(SLOTS),
  localparam int unsigned StoreW = (HANDLE_BITS < hsa_pkg::HandleW) ? HANDLE_BITS
                                                                    : hsa_pkg::HandleW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hsa_pkg::req_t     req_i,
  output logic              rsp_valid_o,
  output hsa_pkg::rsp_t     rsp_o,
  output logic              mem_en_o,
  output logic              mem_we_o,
  output logic [IdxW-1:0]   mem_addr_o,
  output logic [StoreW-1:0] mem_wdata_o,
  input  logic [StoreW-1:0] mem_rdata_i
);

  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (CntW > hsa_pkg::IdW) ? CntW : hsa_pkg::IdW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam logic [CmpW-1:0] SlotsC  = CmpW'(SLOTS);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SClr    = 3'd1;
  localparam logic [2:0] SScan   = 3'd2;
  localparam logic [2:0] SFidRd  = 3'd3;
  localparam logic [2:0] SFidChk = 3'd4;
  localparam logic [2:0] SFin    = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [hsa_pkg::ModeW-1:0]   mode_q, mode_d;
  logic [StoreW-1:0]           hdl_q, hdl_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [IdxW-1:0]             addr_q, addr_d;
  logic                        issue_done_q, issue_done_d;
  logic                        rd_vld_q, rd_vld_d;
  logic                        rd_last_q, rd_last_d;
  logic [IdxW-1:0]             rd_idx_q, rd_idx_d;
  logic                        hit_q, hit_d;
  logic [IdxW-1:0]             hit_idx_q, hit_idx_d;
  logic                        free_q, free_d;
  logic [IdxW-1:0]             free_idx_q, free_idx_d;
  logic                        clr_reply_q, clr_reply_d;
  logic [CntW-1:0]             cnt_q, cnt_d;

  logic [StoreW-1:0]           req_hdl;
  logic [CmpW-1:0]             req_id;
  logic                        id_ok;
  logic [hsa_pkg::IdW-1:0]     rsp_id;
  logic [hsa_pkg::StatusW-1:0] rsp_st;

  assign req_hdl = req_i.handle[StoreW-1:0];
  assign req_id  = CmpW'(req_i.slot_id);
  assign id_ok   = (req_id != '0) && (req_id <= SlotsC);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    hdl_d        = hdl_q;
    idx_d        = idx_q;
    addr_d       = addr_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    clr_reply_d  = clr_reply_q;
    cnt_d        = cnt_q;
    mem_en_o     = 1'b0;
    mem_we_o     = 1'b0;
    mem_addr_o   = addr_q;
    mem_wdata_o  = '0;
    rsp_valid_o  = 1'b0;
    rsp_id       = '0;
    rsp_st       = hsa_pkg::StIgnored;

    unique case (state_q)
      SIdle: begin
        if (start) begin
          mode_d       = req_i.mode;
          hdl_d        = req_hdl;
          idx_d        = IdxW'(req_id - CmpW'(1));
          addr_d       = '0;
          issue_done_d = 1'b0;
          hit_d        = 1'b0;
          free_d       = 1'b0;
          unique case (req_i.mode)
            hsa_pkg::ModeAlloc: begin
              if (req_hdl != '0) begin
                state_d = SScan;
              end else begin
                rsp_valid_o = 1'b1;
              end
            end
            hsa_pkg::ModeFreeId: begin
              if (id_ok) begin
                state_d = SFidRd;
              end else begin
                rsp_valid_o = 1'b1;
              end
            end
            hsa_pkg::ModeFreeHdl: begin
              if (id_ok && (req_hdl != '0)) begin
                state_d = SScan;
              end else begin
                rsp_valid_o = 1'b1;
              end
            end
            hsa_pkg::ModeClearAll: begin
              clr_reply_d = 1'b1;
              state_d     = SClr;
            end
            default: begin
              rsp_valid_o = 1'b1;
            end
          endcase
        end
      end

      SClr: begin
        mem_en_o = 1'b1;
        mem_we_o = 1'b1;
        addr_d   = addr_q + IdxW'(1);
        if (addr_q == LastIdx) begin
          addr_d      = '0;
          cnt_d       = '0;
          clr_reply_d = 1'b0;
          state_d     = SIdle;
          if (clr_reply_q) begin
            rsp_valid_o = 1'b1;
            rsp_st      = hsa_pkg::StFreed;
          end
        end
      end

      SScan: begin
        if (!issue_done_q) begin
          mem_en_o  = 1'b1;
          rd_vld_d  = 1'b1;
          rd_idx_d  = addr_q;
          rd_last_d = (addr_q == LastIdx);
          addr_d    = addr_q + IdxW'(1);
          if (addr_q == LastIdx) begin
            issue_done_d = 1'b1;
          end
        end
        if (rd_vld_q) begin
          // The lowest matching entry and the lowest empty entry are kept.
          if (!hit_q && (mem_rdata_i == hdl_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
          end
          if (!free_q && (mem_rdata_i == '0)) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (rd_last_q) begin
            state_d = SFin;
          end
        end
      end

      SFin: begin
        rsp_valid_o = 1'b1;
        state_d     = SIdle;
        if (mode_q == hsa_pkg::ModeAlloc) begin
          if (hit_q) begin
            rsp_id = hsa_pkg::IdW'(CmpW'(hit_idx_q) + CmpW'(1));
            rsp_st = hsa_pkg::StHeld;
          end else if (free_q) begin
            mem_en_o    = 1'b1;
            mem_we_o    = 1'b1;
            mem_addr_o  = free_idx_q;
            mem_wdata_o = hdl_q;
            cnt_d       = cnt_q + CntW'(1);
            rsp_id      = hsa_pkg::IdW'(CmpW'(free_idx_q) + CmpW'(1));
            rsp_st      = hsa_pkg::StNew;
          end else begin
            rsp_st = hsa_pkg::StFull;
          end
        end else if (hit_q) begin
          mem_en_o   = 1'b1;
          mem_we_o   = 1'b1;
          mem_addr_o = hit_idx_q;
          cnt_d      = cnt_q - CntW'(1);
          rsp_st     = hsa_pkg::StFreed;
        end
      end

      SFidRd: begin
        mem_en_o   = 1'b1;
        mem_addr_o = idx_q;
        state_d    = SFidChk;
      end

      SFidChk: begin
        rsp_valid_o = 1'b1;
        state_d     = SIdle;
        if (mem_rdata_i != '0) begin
          mem_en_o   = 1'b1;
          mem_we_o   = 1'b1;
          mem_addr_o = idx_q;
          cnt_d      = cnt_q - CntW'(1);
          rsp_st     = hsa_pkg::StFreed;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign busy                = (state_q != SIdle);
  assign rsp_o.result_id     = rsp_id;
  assign rsp_o.status        = rsp_st;
  assign rsp_o.used_count    = hsa_pkg::IdW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClr;
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      clr_reply_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      rd_last_q    <= rd_last_d;
      hit_q        <= hit_d;
      free_q       <= free_d;
      clr_reply_q  <= clr_reply_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    hdl_q      <= hdl_d;
    idx_q      <= idx_d;
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

endmodule

[tb/hsa_checker.sv]
// ----------------------------------------------------------------------------
// Handle slot ID allocator checker
// Watches the request and result channels, keeps its own slot table and
// compares every result beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module hsa_checker #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  hsa_pkg::req_t req_i,
  input  logic          res_valid_i,
  input  hsa_pkg::rsp_t res_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hsa_pkg::HandleW-1:0] HandleMask = (HANDLE_BITS >= hsa_pkg::HandleW) ?
      {hsa_pkg::HandleW{1'b1}} :
      ({hsa_pkg::HandleW{1'b1}} >> (hsa_pkg::HandleW - HANDLE_BITS));

  logic [hsa_pkg::HandleW-1:0] slot_tbl [SLOTS];
  int unsigned                 used_slots;
  hsa_pkg::rsp_t               expected_rsp_q [$];
  int unsigned                 mismatch_cnt;
  int unsigned                 rsp_cnt;

  function automatic int unsigned find_slot(input logic [hsa_pkg::HandleW-1:0] h);
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (slot_tbl[i] == h) return i;
    end
    return SLOTS;
  endfunction

  function automatic void clear_table();
    for (int unsigned i = 0; i < SLOTS; i++) slot_tbl[i] = '0;
    used_slots = 0;
  endfunction

  // Applies one request to the shadow table and returns the result it causes.
  function automatic hsa_pkg::rsp_t apply_request(input hsa_pkg::req_t r);
    hsa_pkg::rsp_t               o;
    logic [hsa_pkg::HandleW-1:0] h;
    int unsigned                 idx;
    h           = r.handle & HandleMask;
    o.result_id = '0;
    o.status    = hsa_pkg::StIgnored;
    case (r.mode)
      hsa_pkg::ModeAlloc: begin
        if (h != '0) begin
          idx = find_slot(h);
          if (idx < SLOTS) begin
            o.result_id = hsa_pkg::IdW'(idx + 1);
            o.status    = hsa_pkg::StHeld;
          end else begin
            idx = find_slot('0);
            if (idx < SLOTS) begin
              slot_tbl[idx] = h;
              used_slots++;
              o.result_id = hsa_pkg::IdW'(idx + 1);
              o.status    = hsa_pkg::StNew;
            end else begin
              o.status = hsa_pkg::StFull;
            end
          end
        end
      end
      hsa_pkg::ModeFreeId: begin
        if (r.slot_id >= 1 && r.slot_id <= SLOTS && slot_tbl[r.slot_id - 1] != '0) begin
          slot_tbl[r.slot_id - 1] = '0;
          used_slots--;
          o.status = hsa_pkg::StFreed;
        end
      end
      hsa_pkg::ModeFreeHdl: begin
        // The recorded ID is only a range check; the slot is found by search.
        if (h != '0 && r.slot_id >= 1 && r.slot_id <= SLOTS) begin
          idx = find_slot(h);
          if (idx < SLOTS) begin
            slot_tbl[idx] = '0;
            used_slots--;
            o.status = hsa_pkg::StFreed;
          end
        end
      end
      default: begin
        clear_table();
        o.status = hsa_pkg::StFreed;
      end
    endcase
    o.used_count = hsa_pkg::IdW'(used_slots);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result beat %0d: %s got %0d, expected %0d",
             rsp_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hsa_pkg::rsp_t want;
    if (!rst_ni) begin
      clear_table();
      expected_rsp_q.delete();
      mismatch_cnt = 0;
      rsp_cnt      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected beat, status", int'(res_i.status), -1);
        end else begin
          want = expected_rsp_q.pop_front();
          if (res_i.result_id != want.result_id)
            report_mismatch("result_id", int'(res_i.result_id), int'(want.result_id));
          if (res_i.status != want.status)
            report_mismatch("status", int'(res_i.status), int'(want.status));
          if (res_i.used_count != want.used_count)
            report_mismatch("used_count", int'(res_i.used_count), int'(want.used_count));
        end
        rsp_cnt++;
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(apply_request(req_i));
      fail_count_o <= mismatch_cnt;
      pending_o    <= expected_rsp_q.size();
    end
  end

endmodule

[tb/tb_handle_slot_id_allocator_top.sv]
// ----------------------------------------------------------------------------
// Handle slot ID allocator testbench
// Drives directed and random allocate, free and clear requests through the
// start/busy handshake and lets a checker compare every result beat.
// ----------------------------------------------------------------------------
module tb_handle_slot_id_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS         = 32;
  localparam int unsigned HANDLE_BITS   = 32;
  localparam int unsigned PoolSize      = 40;
  localparam int unsigned ItemsPerPhase = 182;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  hsa_pkg::req_t req_i;
  logic          res_valid_o;
  hsa_pkg::rsp_t res_o;
  int unsigned   fail_count;
  int unsigned   pending;

  // A pool of handles a bit larger than the table, so that requests hit held
  // handles often and the table runs full now and then.
  logic [hsa_pkg::HandleW-1:0] handle_pool [PoolSize];

  always #10 clk_i = ~clk_i;

  handle_slot_id_allocator_top #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  hsa_checker #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .res_valid_i  (res_valid_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic hsa_pkg::req_t make_req(input logic [hsa_pkg::ModeW-1:0] mode,
                                             input logic [hsa_pkg::HandleW-1:0] handle,
                                             input logic [hsa_pkg::IdW-1:0] slot_id);
    hsa_pkg::req_t r;
    r.mode    = mode;
    r.handle  = handle;
    r.slot_id = slot_id;
    return r;
  endfunction

  // Random request: mostly pool handles and in-range IDs, with a share of
  // null handles, stray handles and IDs outside 1..SLOTS mixed in.
  function automatic hsa_pkg::req_t random_request(input int unsigned alloc_pct);
    int unsigned                 pick;
    logic [hsa_pkg::HandleW-1:0] h;
    logic [hsa_pkg::IdW-1:0]     id;
    pick = $urandom_range(0, 99);
    h    = handle_pool[$urandom_range(0, PoolSize - 1)];
    id   = hsa_pkg::IdW'($urandom_range(1, SLOTS));
    if ($urandom_range(0, 9) == 0)
      id = hsa_pkg::IdW'($urandom_range(0, 1) ? 0 : $urandom_range(SLOTS + 1, 63));
    if ($urandom_range(0, 19) == 0) h = $urandom;
    if ($urandom_range(0, 29) == 0) h = '0;
    if (pick < alloc_pct)
      return make_req(hsa_pkg::ModeAlloc, h, hsa_pkg::IdW'($urandom));
    if (pick < 98)
      return make_req($urandom_range(0, 1) ? hsa_pkg::ModeFreeId : hsa_pkg::ModeFreeHdl,
                      h, id);
    return make_req(hsa_pkg::ModeClearAll, $urandom, hsa_pkg::IdW'($urandom));
  endfunction

  // Presents one request beat and returns at the edge that takes it. The
  // busy value read right after the edge is the one the edge sampled.
  task automatic issue_request(input hsa_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drops start for a random number of cycles. Long gaps can cover a whole
  // table scan, so the next beat lands on every phase of the block's work.
  task automatic sender_gap(input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct)
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send(input hsa_pkg::req_t r, input int unsigned idle_pct);
    issue_request(r);
    sender_gap(idle_pct);
  endtask

  // Holds the sender until every predicted result has arrived. The pending
  // count is registered, so it is trusted only once a clock edge has updated it.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_pct;
    int unsigned alloc_pct;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    for (int unsigned i = 0; i < PoolSize; i++) begin
      handle_pool[i] = $urandom;
      if (handle_pool[i] == '0) handle_pool[i] = 1;
    end
    handle_pool[0] = {hsa_pkg::HandleW{1'b1}};
    handle_pool[1] = {{(hsa_pkg::HandleW - 1){1'b0}}, 1'b1};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The block sweeps its RAM after reset and holds busy
    // meanwhile; the handshake simply waits that out.
    idle_pct = 35;
    send(make_req(hsa_pkg::ModeAlloc, '0, '0), idle_pct);               // null handle
    send(make_req(hsa_pkg::ModeFreeId, '0, '0), idle_pct);              // ID zero
    send(make_req(hsa_pkg::ModeFreeId, '0, 6'd1), idle_pct);            // slot empty
    send(make_req(hsa_pkg::ModeFreeId, '0, hsa_pkg::IdW'(SLOTS + 1)),
         idle_pct);                                                     // just past the table
    send(make_req(hsa_pkg::ModeFreeId, '0, {hsa_pkg::IdW{1'b1}}),
         idle_pct);                                                     // largest ID field
    send(make_req(hsa_pkg::ModeFreeHdl, '0, 6'd1), idle_pct);           // null handle
    send(make_req(hsa_pkg::ModeAlloc, {hsa_pkg::HandleW{1'b1}}, {hsa_pkg::IdW{1'b1}}),
         idle_pct);
    send(make_req(hsa_pkg::ModeAlloc, {hsa_pkg::HandleW{1'b1}}, '0),
         idle_pct);                                                     // already held
    send(make_req(hsa_pkg::ModeAlloc, 32'h0000_0001, '0), idle_pct);
    // A held handle with its recorded ID out of range is left in place.
    send(make_req(hsa_pkg::ModeFreeHdl, {hsa_pkg::HandleW{1'b1}}, '0), idle_pct);
    send(make_req(hsa_pkg::ModeFreeHdl, {hsa_pkg::HandleW{1'b1}}, hsa_pkg::IdW'(SLOTS + 1)),
         idle_pct);
    send(make_req(hsa_pkg::ModeFreeHdl, {hsa_pkg::HandleW{1'b1}}, hsa_pkg::IdW'(SLOTS)),
         idle_pct);
    send(make_req(hsa_pkg::ModeFreeHdl, {hsa_pkg::HandleW{1'b1}}, 6'd1),
         idle_pct);                                                     // no longer held
    // The next new handle must fill the hole left at the lowest slot.
    send(make_req(hsa_pkg::ModeAlloc, 32'h8000_0000, '0), idle_pct);
    send(make_req(hsa_pkg::ModeAlloc, 32'h0000_0001, '0), idle_pct);
    send(make_req(hsa_pkg::ModeFreeId, '0, 6'd2), idle_pct);
    send(make_req(hsa_pkg::ModeFreeId, '0, hsa_pkg::IdW'(SLOTS)),
         idle_pct);                                                     // last slot, empty
    send(make_req(hsa_pkg::ModeClearAll, {hsa_pkg::HandleW{1'b1}}, {hsa_pkg::IdW{1'b1}}),
         idle_pct);

    // Random part in three phases: the sender idles 35 percent of the time,
    // then 45 percent, then never. Each phase opens with a clear followed by
    // enough distinct allocations to run the table full.
    for (int unsigned ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 35 : (ph == 1) ? 45 : 0;
      send(make_req(hsa_pkg::ModeClearAll, $urandom, hsa_pkg::IdW'($urandom)), idle_pct);
      for (int unsigned k = 0; k < SLOTS + 2; k++)
        send(make_req(hsa_pkg::ModeAlloc, handle_pool[k], hsa_pkg::IdW'($urandom)),
             idle_pct);
      alloc_pct = 55;
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        // Shift the mix every 32 beats between draining and filling.
        if (n % 32 == 0) begin
          case ($urandom_range(0, 2))
            0:       alloc_pct = 30;
            1:       alloc_pct = 55;
            default: alloc_pct = 80;
          endcase
        end
        send(random_request(alloc_pct), idle_pct);
      end
      if (ph < 2) drain();
    end

    // Wait for the last results, then let a full scan's worth of cycles pass
    // so that any stray beat would still be caught.
    drain();
    repeat (SLOTS + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/hsa_pkg.sv
hw/rtl/hsa_ram.sv
hw/rtl/hsa_ctrl.sv
hw/rtl/handle_slot_id_allocator_top.sv
tb/hsa_checker.sv
tb/tb_handle_slot_id_allocator_top.sv
